FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: hw/rtl/pcg32_pkg.sv
// types, constants and codes for the permuted lcg random generator
`timescale 1ns / 1ps
package pcg32_pkg;

  localparam int STATE_W     = 64;
  localparam int WORD_W      = 32;
  localparam int DIV_CNT_W   = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [STATE_W-1:0] LCG_MULT = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0]  MULT_LO  = LCG_MULT[31:0];
  localparam logic [WORD_W-1:0]  MULT_HI  = LCG_MULT[63:32];

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED_STATE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_SELECT = 1'b1;

  typedef enum logic [1:0] {
    OP_SEED    = 2'd0,
    OP_RAW     = 2'd1,
    OP_BOUNDED = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SEED_LOAD,
    DP_DRAW_LOAD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_MUL3,
    DP_STATE_UPD,
    DP_DIV_INIT_THR,
    DP_DIV_INIT_RAW,
    DP_DIV_STEP,
    DP_THR_SAVE,
    DP_RES_ZERO,
    DP_RES_RAW,
    DP_RES_REM
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DRAW,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_UPD,
    ST_CHECK,
    ST_THR_DIV,
    ST_THR_SAVE,
    ST_RES_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    dp_cmd_t cmd;
    logic    capture;
  } ctrl_t;

  typedef struct packed {
    logic bound_zero;
    logic div_last;
    logic draw_ok;
  } status_t;

endpackage

FILE: hw/rtl/permuted_lcg_random_32_unit.sv
// Top level of the 32-bit permuted lcg random generator (64-bit state).
// Seed: dispatch, multiply, state update, finish; a raw draw adds a draw load first.
// Bounded: threshold remainder, draws until accepted, result remainder; 32 steps each.
// One transaction at a time; the next is accepted the cycle after the result is loaded,
// even while it waits in the output register. Synchronous reset clears state to 0,
// increment to 1, seed and stream registers to 0.
`timescale 1ns / 1ps
module permuted_lcg_random_32_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic [pcg32_pkg::WORD_W-1:0]        bound,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pcg32_pkg::WORD_W-1:0]        value,
  input  logic                                cfg_write,
  input  logic [pcg32_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcg32_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pcg32_pkg::ctrl_t   ctrl;
  pcg32_pkg::status_t status;

  // sequencer
  pcg32_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .status    (status)
  );

  // arithmetic and storage
  pcg32_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .bound     (bound),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (value)
  );

endmodule

FILE: hw/rtl/pcg32_dp.sv
// datapath: state, increment, shared multiplier, remainder unit, result register
`timescale 1ns / 1ps
module pcg32_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pcg32_pkg::ctrl_t                        ctrl,
  output pcg32_pkg::status_t                      status,
  input  logic [pcg32_pkg::WORD_W-1:0]            bound,
  input  logic                                    cfg_write,
  input  logic [pcg32_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pcg32_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic [pcg32_pkg::WORD_W-1:0]            value
);

  logic [pcg32_pkg::STATE_W-1:0]   seed_state;
  logic [pcg32_pkg::STATE_W-1:0]   stream_select;
  logic [pcg32_pkg::STATE_W-1:0]   lcg_state;
  logic [pcg32_pkg::STATE_W-1:0]   lcg_increment;
  logic [pcg32_pkg::STATE_W-1:0]   mop;
  logic [pcg32_pkg::STATE_W-1:0]   prod;
  logic [pcg32_pkg::STATE_W-1:0]   acc;
  logic [pcg32_pkg::WORD_W-1:0]    bound_r;
  logic [pcg32_pkg::WORD_W-1:0]    raw;
  logic [pcg32_pkg::WORD_W-1:0]    thresh;
  logic [pcg32_pkg::WORD_W-1:0]    dvd;
  logic [pcg32_pkg::WORD_W-1:0]    rem;
  logic [pcg32_pkg::DIV_CNT_W-1:0] cnt;

  logic [pcg32_pkg::WORD_W-1:0]    mul_a;
  logic [pcg32_pkg::WORD_W-1:0]    mul_b;
  logic [pcg32_pkg::STATE_W-1:0]   inc_new;
  logic [pcg32_pkg::WORD_W-1:0]    xsh;
  logic [2*pcg32_pkg::WORD_W-1:0]  xsh2;
  logic [pcg32_pkg::WORD_W-1:0]    perm;
  logic [pcg32_pkg::WORD_W:0]      trial;
  logic [pcg32_pkg::WORD_W:0]      diff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_state    <= '0;
      stream_select <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcg32_pkg::REG_SEED_STATE:    seed_state    <= cfg_data;
        pcg32_pkg::REG_STREAM_SELECT: stream_select <= cfg_data;
        default: ;
      endcase
    end
  end

  // increment from stream number
  assign inc_new = {stream_select[pcg32_pkg::STATE_W-2:0], 1'b1};

  // xorshift of the high bits, then rotate by the top five bits
  always_comb begin
    xsh  = lcg_state[58:27] ^ {13'b0, lcg_state[63:45]};
  end
  assign xsh2 = {xsh, xsh} >> lcg_state[63:59];
  assign perm = xsh2[pcg32_pkg::WORD_W-1:0];

  // shared 32x32 multiplier operand select
  always_comb begin
    mul_a = mop[31:0];
    mul_b = pcg32_pkg::MULT_LO;
    unique case (ctrl.cmd)
      pcg32_pkg::DP_MUL1: mul_a = mop[63:32];
      pcg32_pkg::DP_MUL2: mul_b = pcg32_pkg::MULT_HI;
      default: ;
    endcase
  end

  // one restoring remainder step
  assign trial = {rem, dvd[pcg32_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, bound_r};

  // state and increment, reset to zero and one
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state     <= '0;
      lcg_increment <= pcg32_pkg::STATE_W'(1);
    end else begin
      unique case (ctrl.cmd)
        pcg32_pkg::DP_SEED_LOAD: lcg_increment <= inc_new;
        pcg32_pkg::DP_STATE_UPD: lcg_state     <= acc + lcg_increment;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      bound_r <= bound;
    end
    unique case (ctrl.cmd)
      pcg32_pkg::DP_SEED_LOAD: mop <= inc_new + seed_state;
      pcg32_pkg::DP_DRAW_LOAD: begin
        mop <= lcg_state;
        raw <= perm;
      end
      pcg32_pkg::DP_MUL0: prod <= mul_a * mul_b;
      pcg32_pkg::DP_MUL1: begin
        prod <= mul_a * mul_b;
        acc  <= prod;
      end
      pcg32_pkg::DP_MUL2: begin
        prod        <= mul_a * mul_b;
        acc[63:32]  <= acc[63:32] + prod[31:0];
      end
      pcg32_pkg::DP_MUL3: acc[63:32] <= acc[63:32] + prod[31:0];
      pcg32_pkg::DP_DIV_INIT_THR: begin
        dvd <= pcg32_pkg::WORD_W'(0) - bound_r;
        rem <= '0;
        cnt <= '0;
      end
      pcg32_pkg::DP_DIV_INIT_RAW: begin
        dvd <= raw;
        rem <= '0;
        cnt <= '0;
      end
      pcg32_pkg::DP_DIV_STEP: begin
        dvd <= {dvd[pcg32_pkg::WORD_W-2:0], 1'b0};
        rem <= diff[pcg32_pkg::WORD_W] ? trial[pcg32_pkg::WORD_W-1:0]
                                       : diff[pcg32_pkg::WORD_W-1:0];
        cnt <= cnt + pcg32_pkg::DIV_CNT_W'(1);
      end
      pcg32_pkg::DP_THR_SAVE: thresh <= rem;
      pcg32_pkg::DP_RES_ZERO: value  <= '0;
      pcg32_pkg::DP_RES_RAW:  value  <= raw;
      pcg32_pkg::DP_RES_REM:  value  <= rem;
      default: ;
    endcase
  end

  // status back to the controller
  assign status.bound_zero = (bound_r == '0);
  assign status.div_last   = &cnt;
  assign status.draw_ok    = (raw >= thresh);

endmodule

FILE: hw/rtl/pcg32_ctrl.sv
// controller: operation sequencing and output handshake
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcg32_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pcg32_pkg::ctrl_t      ctrl,
  input  pcg32_pkg::status_t    status
);

  pcg32_pkg::state_t  state;
  pcg32_pkg::state_t  state_next;
  pcg32_pkg::opcode_t op;
  pcg32_pkg::opcode_t op_next;
  logic               bnd;
  logic               bnd_next;
  logic               out_valid_next;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcg32_pkg::ST_IDLE;
      op        <= pcg32_pkg::OP_NOP;
      bnd       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      bnd       <= bnd_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != pcg32_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    op_next        = op;
    bnd_next       = bnd;
    out_valid_next = out_valid & out_stall;
    ctrl.cmd       = pcg32_pkg::DP_NOP;
    ctrl.capture   = 1'b0;
    unique case (state)
      pcg32_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          op_next      = pcg32_pkg::opcode_t'(opcode);
          state_next   = pcg32_pkg::ST_DISPATCH;
        end
      end
      pcg32_pkg::ST_DISPATCH: begin
        bnd_next = 1'b0;
        unique case (op)
          pcg32_pkg::OP_SEED: begin
            ctrl.cmd   = pcg32_pkg::DP_SEED_LOAD;
            state_next = pcg32_pkg::ST_MUL0;
          end
          pcg32_pkg::OP_RAW: state_next = pcg32_pkg::ST_DRAW;
          pcg32_pkg::OP_BOUNDED: begin
            if (status.bound_zero) begin
              state_next = pcg32_pkg::ST_DRAW;
            end else begin
              bnd_next   = 1'b1;
              ctrl.cmd   = pcg32_pkg::DP_DIV_INIT_THR;
              state_next = pcg32_pkg::ST_THR_DIV;
            end
          end
          default: state_next = pcg32_pkg::ST_FINISH;
        endcase
      end
      pcg32_pkg::ST_THR_DIV: begin
        ctrl.cmd = pcg32_pkg::DP_DIV_STEP;
        if (status.div_last) begin
          state_next = pcg32_pkg::ST_THR_SAVE;
        end
      end
      pcg32_pkg::ST_THR_SAVE: begin
        ctrl.cmd   = pcg32_pkg::DP_THR_SAVE;
        state_next = pcg32_pkg::ST_DRAW;
      end
      pcg32_pkg::ST_DRAW: begin
        ctrl.cmd   = pcg32_pkg::DP_DRAW_LOAD;
        state_next = pcg32_pkg::ST_MUL0;
      end
      pcg32_pkg::ST_MUL0: begin
        ctrl.cmd   = pcg32_pkg::DP_MUL0;
        state_next = pcg32_pkg::ST_MUL1;
      end
      pcg32_pkg::ST_MUL1: begin
        ctrl.cmd   = pcg32_pkg::DP_MUL1;
        state_next = pcg32_pkg::ST_MUL2;
      end
      pcg32_pkg::ST_MUL2: begin
        ctrl.cmd   = pcg32_pkg::DP_MUL2;
        state_next = pcg32_pkg::ST_MUL3;
      end
      pcg32_pkg::ST_MUL3: begin
        ctrl.cmd   = pcg32_pkg::DP_MUL3;
        state_next = pcg32_pkg::ST_UPD;
      end
      pcg32_pkg::ST_UPD: begin
        ctrl.cmd   = pcg32_pkg::DP_STATE_UPD;
        state_next = bnd ? pcg32_pkg::ST_CHECK : pcg32_pkg::ST_FINISH;
      end
      pcg32_pkg::ST_CHECK: begin
        // rejected draws go round again
        if (status.draw_ok) begin
          ctrl.cmd   = pcg32_pkg::DP_DIV_INIT_RAW;
          state_next = pcg32_pkg::ST_RES_DIV;
        end else begin
          state_next = pcg32_pkg::ST_DRAW;
        end
      end
      pcg32_pkg::ST_RES_DIV: begin
        ctrl.cmd = pcg32_pkg::DP_DIV_STEP;
        if (status.div_last) begin
          state_next = pcg32_pkg::ST_FINISH;
        end
      end
      pcg32_pkg::ST_FINISH: begin
        // load the output register once it is free or being taken
        if (!out_valid || !out_stall) begin
          if (op == pcg32_pkg::OP_SEED || op == pcg32_pkg::OP_NOP) begin
            ctrl.cmd = pcg32_pkg::DP_RES_ZERO;
          end else if (bnd) begin
            ctrl.cmd = pcg32_pkg::DP_RES_REM;
          end else begin
            ctrl.cmd = pcg32_pkg::DP_RES_RAW;
          end
          out_valid_next = 1'b1;
          state_next     = pcg32_pkg::ST_IDLE;
        end
      end
      default: state_next = pcg32_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_AT(a_out_from_finish, clk, rst, $rose(out_valid) |-> $past(state == pcg32_pkg::ST_FINISH))
  `ASSERT_AT(a_accept_dispatch, clk, rst, (in_valid && !in_stall) |=> (state == pcg32_pkg::ST_DISPATCH))
  `ASSERT_NEVER(a_no_div_zero, clk, rst, (state == pcg32_pkg::ST_THR_DIV) && status.bound_zero)

endmodule

FILE: sim/pcg32_result_checker.sv
// result checker for the permuted lcg generator: predicts every value and compares it
`timescale 1ns / 1ps
module pcg32_result_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       opcode,
  input  logic [pcg32_pkg::WORD_W-1:0]     bound,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [pcg32_pkg::WORD_W-1:0]     value,
  input  logic                             cfg_write,
  input  logic [pcg32_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcg32_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending
);

  // copies of the configuration and of the generator state
  logic [pcg32_pkg::STATE_W-1:0] seed_reg;
  logic [pcg32_pkg::STATE_W-1:0] stream_reg;
  logic [pcg32_pkg::STATE_W-1:0] gen_state;
  logic [pcg32_pkg::STATE_W-1:0] gen_inc;

  // predicted values in the order the transactions were accepted
  logic [pcg32_pkg::WORD_W-1:0] expected_words[$];

  // xorshift then rotate, taken from the state before it advances
  function automatic logic [pcg32_pkg::WORD_W-1:0] permute_word(
      input logic [pcg32_pkg::STATE_W-1:0] old);
    logic [pcg32_pkg::STATE_W-1:0] folded;
    logic [pcg32_pkg::WORD_W-1:0]  mixed;
    logic [4:0]                    rot;
    folded = ((old >> 18) ^ old) >> 27;
    mixed  = folded[pcg32_pkg::WORD_W-1:0];
    rot    = old[63:59];
    if (rot == 5'd0) return mixed;
    return (mixed >> rot) | (mixed << (pcg32_pkg::WORD_W - rot));
  endfunction

  // one multiply-add step; returns the word of the old state
  function automatic logic [pcg32_pkg::WORD_W-1:0] step_and_draw();
    logic [pcg32_pkg::STATE_W-1:0] old;
    old       = gen_state;
    gen_state = old * pcg32_pkg::LCG_MULT + gen_inc;
    return permute_word(old);
  endfunction

  // value produced by one transaction, advancing the generator copy
  function automatic logic [pcg32_pkg::WORD_W-1:0] next_random_word(
      input pcg32_pkg::opcode_t op, input logic [pcg32_pkg::WORD_W-1:0] lim);
    logic [pcg32_pkg::WORD_W-1:0] word;
    logic [pcg32_pkg::WORD_W-1:0] neg;
    logic [pcg32_pkg::WORD_W-1:0] thr;
    word = '0;
    case (op)
      pcg32_pkg::OP_SEED: begin
        gen_inc   = {stream_reg[pcg32_pkg::STATE_W-2:0], 1'b1};
        gen_state = (gen_inc + seed_reg) * pcg32_pkg::LCG_MULT + gen_inc;
      end
      pcg32_pkg::OP_RAW: word = step_and_draw();
      pcg32_pkg::OP_BOUNDED: begin
        if (lim == '0) begin
          word = step_and_draw();
        end else begin
          // reject draws below (2^32 - bound) mod bound
          neg = -lim;
          thr = neg % lim;
          do word = step_and_draw(); while (word < thr);
          word = word % lim;
        end
      end
      default: word = '0;
    endcase
    return word;
  endfunction

  // follow register writes, accepted inputs and accepted results
  always @(posedge clk) begin
    if (rst) begin
      seed_reg   = '0;
      stream_reg = '0;
      gen_state  = '0;
      gen_inc    = 64'd1;
      expected_words.delete();
      pending    <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pcg32_pkg::REG_SEED_STATE:    seed_reg = cfg_data;
          pcg32_pkg::REG_STREAM_SELECT: stream_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_words.push_back(next_random_word(pcg32_pkg::opcode_t'(opcode), bound));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("value: result transaction with nothing expected, actual %h", value);
          fail_count <= fail_count + 1;
        end else begin
          if (value !== expected_words[0]) begin
            $error("value mismatch: expected %h, actual %h", expected_words[0], value);
            fail_count <= fail_count + 1;
          end
          void'(expected_words.pop_front());
        end
      end
      pending <= expected_words.size();
    end
  end

endmodule

FILE: sim/tb_permuted_lcg_random_32_unit.sv
// top of the testbench: clock, reset, stimulus and verdict for the permuted lcg generator
`timescale 1ns / 1ps
module tb_permuted_lcg_random_32_unit;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASES          = 13;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES    = 120;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       opcode;
  logic [pcg32_pkg::WORD_W-1:0]     bound;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [pcg32_pkg::WORD_W-1:0]     value;
  logic                             cfg_write;
  logic [pcg32_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcg32_pkg::CFG_DATA_W-1:0] cfg_data;

  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;

  permuted_lcg_random_32_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .bound     (bound),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcg32_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .bound      (bound),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side stalls now and then in bursts of random length
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // present one transaction and hold it until accepted
  task automatic send_item(input pcg32_pkg::opcode_t op,
                           input logic [pcg32_pkg::WORD_W-1:0] lim);
    in_valid <= 1'b1;
    opcode   <= op;
    bound    <= lim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender gap of random length now and then
  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every predicted value has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // write both registers on back-to-back edges
  task automatic write_both(input logic [pcg32_pkg::CFG_DATA_W-1:0] seed_val,
                            input logic [pcg32_pkg::CFG_DATA_W-1:0] stream_val);
    cfg_write <= 1'b1;
    cfg_index <= pcg32_pkg::REG_SEED_STATE;
    cfg_data  <= seed_val;
    @(posedge clk);
    cfg_index <= pcg32_pkg::REG_STREAM_SELECT;
    cfg_data  <= stream_val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // register value: extremes now and then, otherwise random
  function automatic logic [pcg32_pkg::CFG_DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    pcg32_pkg::opcode_t           op;
    logic [pcg32_pkg::WORD_W-1:0] lim;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= pcg32_pkg::OP_NOP;
    bound     <= '0;
    cfg_write <= 1'b0;
    cfg_index <= pcg32_pkg::REG_SEED_STATE;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // draws straight from the reset state, edge bounds, high rejection bounds
    send_item(pcg32_pkg::OP_RAW, 32'd0);                 maybe_gap();
    send_item(pcg32_pkg::OP_RAW, 32'hFFFF_FFFF);         maybe_gap();
    send_item(pcg32_pkg::OP_NOP, 32'hFFFF_FFFF);         maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'd0);             maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'd1);             maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'hFFFF_FFFF);     maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'h8000_0001);     maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'd2);             maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'h8000_0000);     maybe_gap();
    drain();

    // all-ones seed and stream
    write_both('1, '1);
    send_item(pcg32_pkg::OP_SEED, 32'd0);                maybe_gap();
    send_item(pcg32_pkg::OP_RAW, 32'h5555_5555);         maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'd3);             maybe_gap();
    send_item(pcg32_pkg::OP_NOP, 32'd0);                 maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'h7FFF_FFFF);     maybe_gap();
    drain();

    // zero seed and stream
    write_both('0, '0);
    send_item(pcg32_pkg::OP_SEED, 32'hAAAA_AAAA);        maybe_gap();
    send_item(pcg32_pkg::OP_RAW, 32'd0);                 maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'd1);             maybe_gap();
    send_item(pcg32_pkg::OP_BOUNDED, 32'd0);             maybe_gap();
    send_item(pcg32_pkg::OP_SEED, 32'hFFFF_FFFF);        maybe_gap();
    send_item(pcg32_pkg::OP_RAW, 32'd0);                 maybe_gap();

    // random phases, each with fresh registers and mostly starting with a seed
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      idle_on <= (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      write_both(pick_reg_value(), pick_reg_value());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 0 && $urandom_range(0, 3) != 0) begin
          op = pcg32_pkg::OP_SEED;
        end else begin
          case ($urandom_range(0, 15))
            0:                op = pcg32_pkg::OP_SEED;
            1:                op = pcg32_pkg::OP_NOP;
            2, 3, 4, 5, 6, 7: op = pcg32_pkg::OP_RAW;
            default:          op = pcg32_pkg::OP_BOUNDED;
          endcase
        end
        case ($urandom_range(0, 7))
          0:       lim = '0;
          1:       lim = '1;
          2:       lim = $urandom_range(1, 16);
          3:       lim = 32'h8000_0000 + $urandom_range(0, 3);
          4:       lim = 32'd1 << $urandom_range(0, 31);
          default: lim = $urandom;
        endcase
        send_item(op, lim);
        maybe_gap();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
